// ----- rtl/psr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Package for the palette scaler/rotator: command codes, state encodings,
// the job record passed from the front end to the back end, and RGB565 packing.
// No dependencies.
package psr_pkg;

  localparam int PSR_SRC_W = 320;
  localparam int PSR_SRC_H = 200;
  localparam int PSR_DST_W = 400;
  localparam int PSR_DST_H = 240;

  localparam int PSR_FAW_MAX = 20;
  localparam int PSR_OFF_W   = 17;
  localparam int PSR_COLOR_W = 16;
  localparam int PSR_QDEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_PAL  = 2'd0,
    CMD_PIX  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_MUL,
    FE_DIV,
    FE_ADDR,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FRD,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    cmd_e                     kind;
    logic                     border;
    logic [PSR_FAW_MAX-1:0]   addr;
    logic [PSR_OFF_W-1:0]     offset;
    logic [7:0]               pal_idx;
    logic [PSR_COLOR_W-1:0]   data;
  } job_t;

  function automatic logic [PSR_COLOR_W-1:0] pack565(logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/psr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module psr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/psr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts items, drops those that do nothing, and works out the
// frame address, border flag and rotated offset in its multiply, divide and address steps. Uses psr_pkg.
module psr_front #(
  parameter int SRC_W = psr_pkg::PSR_SRC_W,
  parameter int SRC_H = psr_pkg::PSR_SRC_H,
  parameter int DST_W = psr_pkg::PSR_DST_W,
  parameter int DST_H = psr_pkg::PSR_DST_H
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         stretch_i,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [1:0]   cmd_i,
  input  wire logic [7:0]   pal_index_i,
  input  wire logic [7:0]   red_i,
  input  wire logic [7:0]   green_i,
  input  wire logic [7:0]   blue_i,
  input  wire logic [8:0]   src_x_i,
  input  wire logic [7:0]   src_y_i,
  input  wire logic [7:0]   pixel_value_i,
  input  wire logic [8:0]   scr_x_i,
  input  wire logic [7:0]   scr_y_i,
  output logic              job_valid_o,
  input  wire logic         job_ready_i,
  output psr_pkg::job_t     job_o
);

  localparam int SXW  = $clog2(SRC_W);
  localparam int SYW  = $clog2(SRC_H);
  localparam int DXW  = $clog2(DST_W);
  localparam int DYW  = $clog2(DST_H);
  localparam int FAW  = $clog2(SRC_W * SRC_H);
  localparam int OFFW = $clog2(DST_W * DST_H);
  localparam int NXW  = $clog2(DST_W * SRC_W);
  localparam int NYW  = $clog2(DST_H * SRC_H);
  localparam int KX   = NXW + $clog2(DST_W + 1);
  localparam int KY   = NYW + $clog2(DST_H + 1);
  localparam int RXW  = KX - $clog2(DST_W) + 2;
  localparam int RYW  = KY - $clog2(DST_H) + 2;
  localparam int PXW  = NXW + RXW;
  localparam int PYW  = NYW + RYW;
  localparam int NXS  = ((DXW > SXW) ? DXW : SXW) + 2;
  localparam int NYS  = ((DYW > SYW) ? DYW : SYW) + 2;
  localparam int OFFX = (DST_W - SRC_W) / 2;
  localparam int OFFY = (DST_H - SRC_H) / 2;

  localparam logic [63:0] RX_FULL = ((64'd1 << KX) + 64'(DST_W) - 64'd1) / 64'(DST_W);
  localparam logic [63:0] RY_FULL = ((64'd1 << KY) + 64'(DST_H) - 64'd1) / 64'(DST_H);
  localparam logic [RXW-1:0] RX = RXW'(RX_FULL);
  localparam logic [RYW-1:0] RY = RYW'(RY_FULL);

  psr_pkg::fe_state_e state_q, state_d;

  psr_pkg::cmd_e          kind_q;
  logic [7:0]             pal_idx_q;
  logic [15:0]            color_q;
  logic [7:0]             pix_q;
  logic [8:0]             src_x_q;
  logic [7:0]             src_y_q;
  logic [8:0]             scr_x_q;
  logic [7:0]             scr_y_q;

  logic [NXW-1:0]         nx_q;
  logic [NYW-1:0]         ny_q;
  logic [OFFW-1:0]        off_q;
  logic [SXW-1:0]         nsx_q;
  logic [SYW-1:0]         nsy_q;
  logic                   nin_q;

  logic [SXW-1:0]         sx_q, sx_d;
  logic [SYW-1:0]         sy_q, sy_d;
  logic                   border_q, border_d;
  logic [FAW-1:0]         addr_q;

  logic                   accept_c;
  logic                   keep_c;
  logic [DXW-1:0]         x_c;
  logic [DYW-1:0]         y_c;
  logic signed [NXS-1:0]  xn_c;
  logic signed [NYS-1:0]  yn_c;
  logic [PXW-1:0]         px_c;
  logic [PYW-1:0]         py_c;

  assign accept_c = in_valid_i && !in_stall_o;

  always_comb begin
    case (psr_pkg::cmd_e'(cmd_i))
      psr_pkg::CMD_PAL:  keep_c = 1'b1;
      psr_pkg::CMD_PIX:  keep_c = (32'(src_x_i) < 32'(SRC_W)) && (32'(src_y_i) < 32'(SRC_H));
      psr_pkg::CMD_READ: keep_c = (32'(scr_x_i) < 32'(DST_W)) && (32'(scr_y_i) < 32'(DST_H));
      default:           keep_c = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psr_pkg::FE_IDLE: begin
        if (accept_c && keep_c) begin
          state_d = psr_pkg::FE_MUL;
        end
      end
      psr_pkg::FE_MUL:  state_d = psr_pkg::FE_DIV;
      psr_pkg::FE_DIV:  state_d = psr_pkg::FE_ADDR;
      psr_pkg::FE_ADDR: state_d = psr_pkg::FE_PUSH;
      psr_pkg::FE_PUSH: begin
        if (job_ready_i) begin
          state_d = (accept_c && keep_c) ? psr_pkg::FE_MUL : psr_pkg::FE_IDLE;
        end
      end
      default: state_d = psr_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    job_valid_o = 1'b0;
    case (state_q)
      psr_pkg::FE_IDLE: in_stall_o = 1'b0;
      psr_pkg::FE_PUSH: begin
        job_valid_o = 1'b1;
        in_stall_o  = !job_ready_i;
      end
      default: begin
        in_stall_o  = 1'b1;
        job_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psr_pkg::FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_c) begin
      kind_q    <= psr_pkg::cmd_e'(cmd_i);
      pal_idx_q <= pal_index_i;
      color_q   <= psr_pkg::pack565(red_i, green_i, blue_i);
      pix_q     <= pixel_value_i;
      src_x_q   <= src_x_i;
      src_y_q   <= src_y_i;
      scr_x_q   <= scr_x_i;
      scr_y_q   <= scr_y_i;
    end
  end

  assign x_c  = DXW'(scr_x_q);
  assign y_c  = DYW'(scr_y_q);
  assign xn_c = $signed(NXS'(x_c)) - $signed(NXS'(OFFX));
  assign yn_c = $signed(NYS'(y_c)) - $signed(NYS'(OFFY));

  always_ff @(posedge clk_i) begin
    nx_q  <= NXW'(x_c) * NXW'(SRC_W);
    ny_q  <= NYW'(y_c) * NYW'(SRC_H);
    off_q <= OFFW'(x_c) * OFFW'(DST_H) + OFFW'(DST_H - 1) - OFFW'(y_c);
    nsx_q <= SXW'(xn_c);
    nsy_q <= SYW'(yn_c);
    nin_q <= (xn_c >= 0) && (xn_c < $signed(NXS'(SRC_W))) &&
             (yn_c >= 0) && (yn_c < $signed(NYS'(SRC_H)));
  end

  // Floor division by the screen size is an exact reciprocal multiply.
  assign px_c = PXW'(nx_q) * PXW'(RX);
  assign py_c = PYW'(ny_q) * PYW'(RY);

  always_comb begin
    sx_d     = '0;
    sy_d     = '0;
    border_d = 1'b0;
    if (kind_q == psr_pkg::CMD_PIX) begin
      sx_d = SXW'(src_x_q);
      sy_d = SYW'(src_y_q);
    end else if (kind_q == psr_pkg::CMD_READ) begin
      if (stretch_i) begin
        sx_d = SXW'(px_c >> KX);
        sy_d = SYW'(py_c >> KY);
      end else begin
        sx_d     = nsx_q;
        sy_d     = nsy_q;
        border_d = !nin_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    border_q <= border_d;
    addr_q   <= FAW'(sy_q) * FAW'(SRC_W) + FAW'(sx_q);
  end

  always_comb begin
    job_o.kind    = kind_q;
    job_o.border  = border_q;
    job_o.addr    = psr_pkg::PSR_FAW_MAX'(addr_q);
    job_o.offset  = psr_pkg::PSR_OFF_W'(off_q);
    job_o.pal_idx = pal_idx_q;
    job_o.data    = (kind_q == psr_pkg::CMD_PAL) ? color_q : {8'd0, pix_q};
  end

endmodule
`default_nettype wire

// ----- rtl/psr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Short job queue between the front end and the back end.
// Uses psr_pkg for the job record and its depth.
module psr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire psr_pkg::job_t push_job_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output psr_pkg::job_t      pop_job_o
);

  localparam int QD  = psr_pkg::PSR_QDEPTH;
  localparam int QAW = $clog2(QD);
  localparam int CW  = $clog2(QD + 1);

  psr_pkg::job_t   slot_q [QD];
  logic [QAW-1:0]  wptr_q;
  logic [QAW-1:0]  rptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = count_q != CW'(QD);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_job_o    = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QAW'(QD - 1)) ? '0 : wptr_q + QAW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QAW'(QD - 1)) ? '0 : rptr_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(QD))
    else $error("Job queue holds more items than its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("Job queue count did not follow a lone push.");

endmodule
`default_nettype wire

// ----- rtl/psr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Back end: carries out palette and pixel writes, and performs the frame then
// palette lookup for reads off the border; border reads give colour zero. Uses psr_pkg and two psr_ram instances.
module psr_back #(
  parameter int SRC_W = psr_pkg::PSR_SRC_W,
  parameter int SRC_H = psr_pkg::PSR_SRC_H
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              job_valid_i,
  output logic                                   job_pop_o,
  input  wire psr_pkg::job_t                     job_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [psr_pkg::PSR_OFF_W-1:0]     fb_offset_o,
  output logic      [psr_pkg::PSR_COLOR_W-1:0]   color_o
);

  localparam int FDEPTH = SRC_W * SRC_H;
  localparam int FAW    = $clog2(FDEPTH);

  psr_pkg::bk_state_e state_q, state_d;

  logic [psr_pkg::PSR_OFF_W-1:0]   off_q;
  logic                            border_q;
  logic                            out_valid_q;
  logic [psr_pkg::PSR_OFF_W-1:0]   out_off_q;
  logic [psr_pkg::PSR_COLOR_W-1:0] out_color_q;

  logic                            out_free_c;
  logic                            load_out_c;
  logic                            pal_we_c;
  logic                            frame_we_c;
  logic                            frame_re_c;
  logic                            pal_re_c;
  logic [7:0]                      frame_rdata;
  logic [psr_pkg::PSR_COLOR_W-1:0] pal_rdata;

  assign out_free_c = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      psr_pkg::BK_IDLE: begin
        if (job_valid_i && job_i.kind == psr_pkg::CMD_READ) begin
          state_d = job_i.border ? psr_pkg::BK_DONE : psr_pkg::BK_FRD;
        end
      end
      psr_pkg::BK_FRD: state_d = psr_pkg::BK_DONE;
      psr_pkg::BK_DONE: begin
        if (out_free_c) begin
          state_d = psr_pkg::BK_IDLE;
        end
      end
      default: state_d = psr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o  = 1'b0;
    pal_we_c   = 1'b0;
    frame_we_c = 1'b0;
    frame_re_c = 1'b0;
    pal_re_c   = 1'b0;
    load_out_c = 1'b0;
    case (state_q)
      psr_pkg::BK_IDLE: begin
        job_pop_o  = job_valid_i;
        pal_we_c   = job_valid_i && job_i.kind == psr_pkg::CMD_PAL;
        frame_we_c = job_valid_i && job_i.kind == psr_pkg::CMD_PIX;
        frame_re_c = job_valid_i && job_i.kind == psr_pkg::CMD_READ && !job_i.border;
      end
      psr_pkg::BK_FRD:  pal_re_c   = 1'b1;
      psr_pkg::BK_DONE: load_out_c = out_free_c;
      default: begin
        job_pop_o  = 1'b0;
        load_out_c = 1'b0;
      end
    endcase
  end

  psr_ram #(
    .WIDTH(8),
    .DEPTH(FDEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (frame_we_c),
    .waddr_i(FAW'(job_i.addr)),
    .wdata_i(job_i.data[7:0]),
    .re_i   (frame_re_c),
    .raddr_i(FAW'(job_i.addr)),
    .rdata_o(frame_rdata)
  );

  psr_ram #(
    .WIDTH(psr_pkg::PSR_COLOR_W),
    .DEPTH(256)
  ) u_pal_ram (
    .clk_i  (clk_i),
    .we_i   (pal_we_c),
    .waddr_i(job_i.pal_idx),
    .wdata_i(job_i.data),
    .re_i   (pal_re_c),
    .raddr_i(frame_rdata),
    .rdata_o(pal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psr_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out_c) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o && job_i.kind == psr_pkg::CMD_READ) begin
      off_q    <= job_i.offset;
      border_q <= job_i.border;
    end
    if (load_out_c) begin
      out_off_q   <= off_q;
      out_color_q <= border_q ? '0 : pal_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fb_offset_o = out_off_q;
  assign color_o     = out_color_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == psr_pkg::BK_DONE))
    else $error("Result shown without a finished lookup.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psr_pkg::BK_FRD) |=> (state_q == psr_pkg::BK_DONE))
    else $error("Palette lookup did not follow the frame read.");

endmodule
`default_nettype wire

// ----- rtl/palette_scaler_rotator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A read goes through the front end's multiply, reciprocal divide and address steps,
// the queue, and the back end's frame read and palette read; a native-mode border read
// skips both reads. The front end takes no new item until it pushes its job; items that
// do nothing are dropped on acceptance. The back end does a write as it pops the job.
// Reset clears control state and the stretch register; the frame and palette
// memories are not cleared and must be written before they are read.
module palette_scaler_rotator #(
  parameter int SRC_W = psr_pkg::PSR_SRC_W,
  parameter int SRC_H = psr_pkg::PSR_SRC_H,
  parameter int DST_W = psr_pkg::PSR_DST_W,
  parameter int DST_H = psr_pkg::PSR_DST_H
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic [7:0]                        pal_index_i,
  input  wire logic [7:0]                        red_i,
  input  wire logic [7:0]                        green_i,
  input  wire logic [7:0]                        blue_i,
  input  wire logic [8:0]                        src_x_i,
  input  wire logic [7:0]                        src_y_i,
  input  wire logic [7:0]                        pixel_value_i,
  input  wire logic [8:0]                        scr_x_i,
  input  wire logic [7:0]                        scr_y_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [psr_pkg::PSR_OFF_W-1:0]     fb_offset_o,
  output logic      [psr_pkg::PSR_COLOR_W-1:0]   color_o
);

  logic          stretch_q;
  logic          push_valid;
  logic          push_ready;
  psr_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop;
  psr_pkg::job_t pop_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stretch_q <= 1'b0;
    end else if (cfg_we_i) begin
      stretch_q <= cfg_wdata_i;
    end
  end

  psr_front #(
    .SRC_W(SRC_W),
    .SRC_H(SRC_H),
    .DST_W(DST_W),
    .DST_H(DST_H)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stretch_i    (stretch_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .pal_index_i  (pal_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .src_x_i      (src_x_i),
    .src_y_i      (src_y_i),
    .pixel_value_i(pixel_value_i),
    .scr_x_i      (scr_x_i),
    .scr_y_i      (scr_y_i),
    .job_valid_o  (push_valid),
    .job_ready_i  (push_ready),
    .job_o        (push_job)
  );

  psr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_job_o   (pop_job)
  );

  psr_back #(
    .SRC_W(SRC_W),
    .SRC_H(SRC_H)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_pop_o  (pop),
    .job_i      (pop_job),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .fb_offset_o(fb_offset_o),
    .color_o    (color_o)
  );

endmodule
`default_nettype wire
